// ===== rtl/core/fgks_pkg.sv =====
// ============================================================================
// fgks_pkg : shared types and constants for the k-th successor block
// Field widths, request and register codes, and the sequencer state type.
// ============================================================================
package fgks_pkg;

    // Fixed field widths of the transaction payloads
    localparam int NODE_W     = 10;
    localparam int DIR_IDX_W  = 9;
    localparam int COUNT_W    = 31;
    localparam int NCFG_W     = 11;
    localparam int DCFG_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Request codes carried by req_type
    typedef enum logic [1:0] {
        REQ_NODE  = 2'd0,
        REQ_DIR   = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT = 2'd0,
        CFG_DIR_COUNT  = 2'd1
    } cfg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WSTART,
        S_WALK,
        S_DA,
        S_DB,
        S_DC,
        S_QRY,
        S_QWAIT,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/fgks_ram.sv =====
// ============================================================================
// fgks_ram : generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// ============================================================================
module fgks_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data, hold it between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/functional_graph_kth_successor_top.sv =====
// ============================================================================
// functional_graph_kth_successor_top : k-th successor by binary lifting
// Loads fill a successor table and a direction sequence; a query rebuilds the
// one-round map and the doubling jump table when stale, then composes jumps.
// ============================================================================
//
//  channel | signals                                  | direction | flow
//  --------+------------------------------------------+-----------+-------------
//  in      | in_valid, in_stall, req_type .. start_node | into block| valid/stall
//  out     | out_valid, out_stall, end_node           | out       | valid/stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | into block| valid/ready
//
//  A query with a current jump table goes straight to composing jumps; a
//  stale table is first rebuilt by the walk and then the doubling, each
//  step paced by the single read port of the successor and jump RAMs.
//  The input is stalled while a query runs; a waiting result does not block
//  loads. Reset clears control state only; the RAMs need no clearing pass.
//
module functional_graph_kth_successor_top #(
    parameter int MAX_NODES   = 1024,
    parameter int MAX_DIRS    = 512,
    parameter int JUMP_LEVELS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic [fgks_pkg::NODE_W-1:0]      node_index,
    input  logic [fgks_pkg::NODE_W-1:0]      left_next,
    input  logic [fgks_pkg::NODE_W-1:0]      right_next,
    input  logic [fgks_pkg::DIR_IDX_W-1:0]   dir_index,
    input  logic                             dir_right,
    input  logic [fgks_pkg::COUNT_W-1:0]     round_count,
    input  logic [fgks_pkg::NODE_W-1:0]      start_node,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [fgks_pkg::NODE_W-1:0]      end_node,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fgks_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fgks_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int DW   = (MAX_DIRS > 1) ? $clog2(MAX_DIRS) : 1;
    localparam int LW   = $clog2(JUMP_LEVELS);
    localparam int JAW  = NW + LW;
    localparam int QB   = (JUMP_LEVELS < fgks_pkg::COUNT_W) ? JUMP_LEVELS : fgks_pkg::COUNT_W;
    localparam int BW   = $clog2(QB + 1);
    localparam int SW   = 2 * fgks_pkg::NODE_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fgks_pkg::state_t state_reg, state_next;

    logic [NW-1:0]                    v_reg, v_next;
    logic [DW-1:0]                    d_reg, d_next;
    logic [LW-1:0]                    lv_reg, lv_next;
    logic [BW-1:0]                    b_reg, b_next;
    logic [fgks_pkg::COUNT_W-1:0]     k_reg, k_next;
    logic [NW-1:0]                    pos_reg, pos_next;
    logic                             tv_reg, tv_next;
    logic [fgks_pkg::NCFG_W-1:0]      node_count_reg, node_count_next;
    logic [fgks_pkg::DCFG_W-1:0]      dir_count_reg, dir_count_next;
    logic                             out_valid_reg, out_valid_next;
    logic [fgks_pkg::NODE_W-1:0]      end_node_reg, end_node_next;

    // RAM controls
    logic            succ_we, succ_re;
    logic [NW-1:0]   succ_waddr, succ_raddr;
    logic [SW-1:0]   succ_wdata, succ_rdata;
    logic            dir_we, dir_re;
    logic [DW-1:0]   dir_waddr, dir_raddr;
    logic            dir_wdata, dir_rdata;
    logic            jump_we, jump_re;
    logic [JAW-1:0]  jump_waddr, jump_raddr;
    logic [NW-1:0]   jump_wdata, jump_rdata;

    // Derived values
    logic [fgks_pkg::NODE_W-1:0] walk_nxt;
    logic [NW-1:0]   walk_in_use;
    logic [NW-1:0]   start_in_use;
    logic            v_last, d_last, lv_last;
    logic [LW-1:0]   b_level;
    logic            out_free;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    fgks_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_succ_ram (
        .clk     (clk),
        .wr_en   (succ_we),
        .wr_addr (succ_waddr),
        .wr_data (succ_wdata),
        .rd_en   (succ_re),
        .rd_addr (succ_raddr),
        .rd_data (succ_rdata)
    );

    fgks_ram #(.WIDTH(1), .DEPTH(MAX_DIRS)) u_dir_ram (
        .clk     (clk),
        .wr_en   (dir_we),
        .wr_addr (dir_waddr),
        .wr_data (dir_wdata),
        .rd_en   (dir_re),
        .rd_addr (dir_raddr),
        .rd_data (dir_rdata)
    );

    fgks_ram #(.WIDTH(NW), .DEPTH(MAX_NODES << LW)) u_jump_ram (
        .clk     (clk),
        .wr_en   (jump_we),
        .wr_addr (jump_waddr),
        .wr_data (jump_wdata),
        .rd_en   (jump_re),
        .rd_addr (jump_raddr),
        .rd_data (jump_rdata)
    );

    // ------------------------------------------------------------------
    // Effective counts, walk step and loop ends
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [31:0] nc;
        logic [31:0] dc;
        logic [31:0] nxt_w;
        logic [31:0] st_w;
        nc = 32'(node_count_reg);
        dc = 32'(dir_count_reg);
        if (nc == 32'd0)
        begin
            nc = 32'd1;
        end
        else if (nc > 32'(MAX_NODES))
        begin
            nc = 32'(MAX_NODES);
        end
        if (dc == 32'd0)
        begin
            dc = 32'd1;
        end
        else if (dc > 32'(MAX_DIRS))
        begin
            dc = 32'(MAX_DIRS);
        end

        // pick the successor by the direction bit, fold unused nodes to zero
        walk_nxt = dir_rdata ? succ_rdata[SW-1:fgks_pkg::NODE_W]
                             : succ_rdata[fgks_pkg::NODE_W-1:0];
        nxt_w = 32'(walk_nxt);
        walk_in_use = (nxt_w < nc) ? nxt_w[NW-1:0] : '0;
        st_w = 32'(start_node);
        start_in_use = (st_w < nc) ? st_w[NW-1:0] : '0;

        v_last  = (32'(v_reg) + 32'd1) == nc;
        d_last  = (32'(d_reg) + 32'd1) == dc;
        lv_last = 32'(lv_reg) == 32'(JUMP_LEVELS - 1);
    end

    assign b_level  = LW'(b_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fgks_pkg::S_IDLE:
            begin
                if (in_valid && (req_type == fgks_pkg::REQ_QUERY))
                begin
                    state_next = tv_reg ? fgks_pkg::S_QRY : fgks_pkg::S_WSTART;
                end
            end
            fgks_pkg::S_WSTART:
            begin
                state_next = fgks_pkg::S_WALK;
            end
            fgks_pkg::S_WALK:
            begin
                if (d_last)
                begin
                    state_next = v_last ? fgks_pkg::S_DA : fgks_pkg::S_WSTART;
                end
            end
            fgks_pkg::S_DA:
            begin
                state_next = fgks_pkg::S_DB;
            end
            fgks_pkg::S_DB:
            begin
                state_next = fgks_pkg::S_DC;
            end
            fgks_pkg::S_DC:
            begin
                state_next = (v_last && lv_last) ? fgks_pkg::S_QRY : fgks_pkg::S_DA;
            end
            fgks_pkg::S_QRY:
            begin
                if (32'(b_reg) == 32'(QB))
                begin
                    state_next = fgks_pkg::S_DONE;
                end
                else if (((k_reg >> b_reg) & fgks_pkg::COUNT_W'(1)) != '0)
                begin
                    state_next = fgks_pkg::S_QWAIT;
                end
            end
            fgks_pkg::S_QWAIT:
            begin
                state_next = fgks_pkg::S_QRY;
            end
            fgks_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = fgks_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fgks_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        v_next          = v_reg;
        d_next          = d_reg;
        lv_next         = lv_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        pos_next        = pos_reg;
        tv_next         = tv_reg;
        node_count_next = node_count_reg;
        dir_count_next  = dir_count_reg;
        end_node_next   = end_node_reg;
        out_valid_next  = out_valid_reg && out_stall;

        succ_we    = 1'b0;
        succ_waddr = NW'(32'(node_index));
        succ_wdata = {right_next, left_next};
        succ_re    = 1'b0;
        succ_raddr = v_reg;
        dir_we     = 1'b0;
        dir_waddr  = DW'(32'(dir_index));
        dir_wdata  = dir_right;
        dir_re     = 1'b0;
        dir_raddr  = '0;
        jump_we    = 1'b0;
        jump_waddr = {v_reg, lv_reg};
        jump_wdata = jump_rdata;
        jump_re    = 1'b0;
        jump_raddr = {v_reg, lv_reg - LW'(1)};

        case (state_reg)
            fgks_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (fgks_pkg::req_t'(req_type))
                        fgks_pkg::REQ_NODE:
                        begin
                            tv_next = 1'b0;
                            succ_we = 32'(node_index) < 32'(MAX_NODES);
                        end
                        fgks_pkg::REQ_DIR:
                        begin
                            tv_next = 1'b0;
                            dir_we  = 32'(dir_index) < 32'(MAX_DIRS);
                        end
                        fgks_pkg::REQ_QUERY:
                        begin
                            k_next   = round_count;
                            pos_next = start_in_use;
                            b_next   = '0;
                            v_next   = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            fgks_pkg::S_WSTART:
            begin
                // start the walk of node v at the first direction
                succ_re    = 1'b1;
                succ_raddr = v_reg;
                dir_re     = 1'b1;
                dir_raddr  = '0;
                d_next     = '0;
            end
            fgks_pkg::S_WALK:
            begin
                if (d_last)
                begin
                    jump_we    = 1'b1;
                    jump_waddr = {v_reg, LW'(0)};
                    jump_wdata = walk_in_use;
                    if (v_last)
                    begin
                        v_next  = '0;
                        lv_next = LW'(1);
                    end
                    else
                    begin
                        v_next = v_reg + NW'(1);
                    end
                end
                else
                begin
                    succ_re    = 1'b1;
                    succ_raddr = walk_in_use;
                    dir_re     = 1'b1;
                    dir_raddr  = d_reg + DW'(1);
                    d_next     = d_reg + DW'(1);
                end
            end
            fgks_pkg::S_DA:
            begin
                // fetch the midpoint of the doubled jump
                jump_re    = 1'b1;
                jump_raddr = {v_reg, lv_reg - LW'(1)};
            end
            fgks_pkg::S_DB:
            begin
                jump_re    = 1'b1;
                jump_raddr = {jump_rdata, lv_reg - LW'(1)};
            end
            fgks_pkg::S_DC:
            begin
                jump_we    = 1'b1;
                jump_waddr = {v_reg, lv_reg};
                jump_wdata = jump_rdata;
                if (v_last)
                begin
                    v_next = '0;
                    if (lv_last)
                    begin
                        tv_next = 1'b1;
                    end
                    else
                    begin
                        lv_next = lv_reg + LW'(1);
                    end
                end
                else
                begin
                    v_next = v_reg + NW'(1);
                end
            end
            fgks_pkg::S_QRY:
            begin
                if (32'(b_reg) != 32'(QB))
                begin
                    if (((k_reg >> b_reg) & fgks_pkg::COUNT_W'(1)) != '0)
                    begin
                        jump_re    = 1'b1;
                        jump_raddr = {pos_reg, b_level};
                    end
                    else
                    begin
                        b_next = b_reg + BW'(1);
                    end
                end
            end
            fgks_pkg::S_QWAIT:
            begin
                pos_next = jump_rdata;
                b_next   = b_reg + BW'(1);
            end
            fgks_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    end_node_next  = fgks_pkg::NODE_W'(32'(pos_reg));
                end
            end
            default:
            begin
            end
        endcase

        // Writes to the node or direction count clear the jump table's valid flag
        if (cfg_valid)
        begin
            case (fgks_pkg::cfg_idx_t'(cfg_index))
                fgks_pkg::CFG_NODE_COUNT:
                begin
                    node_count_next = cfg_data[fgks_pkg::NCFG_W-1:0];
                    tv_next         = 1'b0;
                end
                fgks_pkg::CFG_DIR_COUNT:
                begin
                    dir_count_next = cfg_data[fgks_pkg::DCFG_W-1:0];
                    tv_next        = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fgks_pkg::S_IDLE;
            tv_reg         <= 1'b0;
            node_count_reg <= fgks_pkg::NCFG_W'(1);
            dir_count_reg  <= fgks_pkg::DCFG_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tv_reg         <= tv_next;
            node_count_reg <= node_count_next;
            dir_count_reg  <= dir_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload and loop counters
    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        d_reg        <= d_next;
        lv_reg       <= lv_next;
        b_reg        <= b_next;
        k_reg        <= k_next;
        pos_reg      <= pos_next;
        end_node_reg <= end_node_next;
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign in_stall  = (state_reg != fgks_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign end_node  = end_node_reg;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_tv_from_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tv_reg) |-> ($past(state_reg) == fgks_pkg::S_DC))
        else $error("jump table marked valid outside the doubling pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == fgks_pkg::S_DONE))
        else $error("result raised without a finished query");

    a_fresh_query_skips_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fgks_pkg::S_IDLE && in_valid && req_type == fgks_pkg::REQ_QUERY
         && tv_reg) |=> (state_reg == fgks_pkg::S_QRY))
        else $error("query with a valid table did not go straight to the jumps");

    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fgks_pkg::S_QRY || state_reg == fgks_pkg::S_QWAIT) |-> !jump_we)
        else $error("jump table written while a query composes jumps");

endmodule
